### sv/tnnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnnm_pkg
// Shared widths, codes, reset values and types of the descriptor matcher.
// ----------------------------------------------------------------------------
package tnnm_pkg;

  localparam int DIMS_DEF        = 128;
  localparam int MAX_ENTRIES_DEF = 1024;

  localparam int COMP_W   = 16;
  localparam int LABEL_W  = 8;
  localparam int ENTRY_W  = 10;
  localparam int DIM_W    = 7;
  localparam int COUNT_W  = 11;
  localparam int DIST_W   = 39;
  localparam int SQ_W     = 32;
  localparam int CFG_W    = 39;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRONG_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_THR   = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX          = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] STRONG_THR_RESET  = 39'd54358180;
  localparam logic [DIST_W-1:0] ACCEPT_THR_RESET  = 39'd81201725;

  // Tag that travels with one component pair through the distance pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } dist_ctl_t;

endpackage

### sv/tnnm_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnnm_dist
// Squared-distance datapath: square one component difference per cycle and
// accumulate it with saturation, flagging the sum at the last component.
// ----------------------------------------------------------------------------
module tnnm_dist
  import tnnm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  dist_ctl_t                ctl_i,
  input  logic [COMP_W-1:0]        tbl_i,
  input  logic [COMP_W-1:0]        qry_i,
  output logic                     pend_o,
  output logic                     dist_vld_o,
  output logic [DIST_W-1:0]        dist_o
);

  logic signed [COMP_W:0] diff;
  logic        [COMP_W:0] diff_abs;
  logic [COMP_W-1:0]      mag;
  dist_ctl_t              ctla_r;
  logic [SQ_W-1:0]        sq_r;
  logic [DIST_W-1:0]      acc_r;
  logic [DIST_W-1:0]      base;
  logic [DIST_W:0]        sum;
  logic                   dist_vld_r;

  always_comb begin
    diff     = signed'({tbl_i[COMP_W-1], tbl_i}) - signed'({qry_i[COMP_W-1], qry_i});
    diff_abs = diff[COMP_W] ? (-diff) : diff;
    mag      = diff_abs[COMP_W-1:0];
    base     = ctla_r.first ? '0 : acc_r;
    sum      = {1'b0, base} + (DIST_W+1)'(sq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctla_r     <= '0;
      dist_vld_r <= 1'b0;
    end else begin
      ctla_r     <= ctl_i;
      dist_vld_r <= ctla_r.vld && ctla_r.last;
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= SQ_W'(mag * mag);
    if (ctla_r.vld) begin
      acc_r <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    end
  end

  assign pend_o     = ctla_r.vld;
  assign dist_vld_o = dist_vld_r;
  assign dist_o     = acc_r;

endmodule

### sv/thresholded_nearest_neighbour_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thresholded_nearest_neighbour_match
// Labelled descriptor table with a thresholded nearest-neighbour search.
// ----------------------------------------------------------------------------
// Load and query words are taken back to back, but only while busy is low.
// A query word with last_element set raises busy while the block walks
// entries 0 to min(entry_count, MAX_ENTRIES)-1, reading one table component
// per cycle from the single table memory read port, then drains the
// distance pipeline; with a limit of zero it only drains, and a strong
// match ends the walk early. The
// result then appears on the out_ ports for one cycle with out_valid high;
// the receiver cannot stall it and no result is buffered beyond that cycle.
// There is no clearing pass after reset: table, label and query entries
// read before they are written return arbitrary data. Configuration writes
// take effect at once and belong in idle periods only.
// ----------------------------------------------------------------------------
module thresholded_nearest_neighbour_match
  import tnnm_pkg::*;
#(
  parameter int DIMS        = DIMS_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_req_type,
  input  logic [ENTRY_W-1:0]       in_entry_index,
  input  logic [DIM_W-1:0]         in_dim_index,
  input  logic signed [COMP_W-1:0] in_component,
  input  logic [LABEL_W-1:0]       in_label_id,
  input  logic                     in_last_element,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [LABEL_W-1:0]       out_match_label,
  output logic                     out_strong_match,
  output logic [DIST_W-1:0]        out_best_distance_sq
);

  localparam int TBL_DEPTH = MAX_ENTRIES * DIMS;
  localparam int AW = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1) + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  logic [COMP_W-1:0]  tbl_mem [TBL_DEPTH];
  logic [LABEL_W-1:0] lbl_mem [MAX_ENTRIES];
  logic [COMP_W-1:0]  qry_mem [DIMS];

  state_t            state_r, state_nxt;
  logic [EW-1:0]     ent_r, ent_nxt;
  logic [DW-1:0]     dim_r, dim_nxt;
  logic [AW-1:0]     taddr_r, taddr_nxt;
  logic [EW-1:0]     last_ent_r, last_ent_nxt;

  logic [COUNT_W-1:0] entry_cnt_r;
  logic [DIST_W-1:0]  strong_thr_r;
  logic [DIST_W-1:0]  accept_thr_r;

  logic [COMP_W-1:0]  tbl_q;
  logic [COMP_W-1:0]  qry_q;
  logic [LABEL_W-1:0] lbl_q;
  logic [LABEL_W-1:0] lbla_r;
  logic [LABEL_W-1:0] lblb_r;
  dist_ctl_t          c1_r;
  dist_ctl_t          issue_ctl;

  logic               pend;
  logic               dist_vld;
  logic [DIST_W-1:0]  dist_sq;

  logic               found_r;
  logic               strong_r;
  logic [LABEL_W-1:0] best_lbl_r;
  logic [DIST_W-1:0]  best_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [LABEL_W-1:0] out_label_r;
  logic               out_strong_r;
  logic [DIST_W-1:0]  out_dist_r;

  logic               accept;
  logic               go;
  logic               entry_ok;
  logic               dim_ok;
  logic [AW-1:0]      waddr;
  logic [CW-1:0]      lim;
  logic               dim_last;
  logic               ent_last;
  logic               strong_hit;
  logic               pipe_empty;
  logic               emit;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign go     = accept && (in_req_type == REQ_QUERY) && in_last_element;

  assign entry_ok = 32'(in_entry_index) < MAX_ENTRIES;
  assign dim_ok   = 32'(in_dim_index) < DIMS;
  assign waddr    = AW'(AW'(in_entry_index) * AW'(DIMS) + AW'(in_dim_index));

  assign lim = (32'(entry_cnt_r) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(entry_cnt_r);

  assign dim_last   = (32'(dim_r) == DIMS - 1);
  assign ent_last   = (ent_r == last_ent_r);
  assign strong_hit = dist_vld && !strong_r && (dist_sq < strong_thr_r);
  assign pipe_empty = !c1_r.vld && !pend && !dist_vld;
  assign emit       = (state_r == ST_DRAIN) && pipe_empty;

  always_comb begin
    issue_ctl.vld   = (state_r == ST_WALK);
    issue_ctl.first = (dim_r == '0);
    issue_ctl.last  = dim_last;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_cnt_r  <= '0;
      strong_thr_r <= STRONG_THR_RESET;
      accept_thr_r <= ACCEPT_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY_COUNT: begin
          entry_cnt_r <= cfg_wdata[COUNT_W-1:0];
        end
        CFG_STRONG_THR: begin
          strong_thr_r <= cfg_wdata[DIST_W-1:0];
        end
        CFG_ACCEPT_THR: begin
          accept_thr_r <= cfg_wdata[DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // table, label and query memories
  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_LOAD) && entry_ok && dim_ok) begin
      tbl_mem[waddr] <= in_component;
    end
    tbl_q <= tbl_mem[taddr_r];
  end

  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_LOAD) && entry_ok && dim_ok) begin
      lbl_mem[EW'(in_entry_index)] <= in_label_id;
    end
    lbl_q <= lbl_mem[ent_r];
  end

  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_QUERY) && dim_ok) begin
      qry_mem[DW'(in_dim_index)] <= in_component;
    end
    qry_q <= qry_mem[dim_r];
  end

  // walk sequencer
  always_comb begin
    state_nxt    = state_r;
    ent_nxt      = ent_r;
    dim_nxt      = dim_r;
    taddr_nxt    = taddr_r;
    last_ent_nxt = last_ent_r;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          ent_nxt      = '0;
          dim_nxt      = '0;
          taddr_nxt    = '0;
          last_ent_nxt = EW'(lim - CW'(1));
          state_nxt    = (lim == '0) ? ST_DRAIN : ST_WALK;
        end
      end
      ST_WALK: begin
        taddr_nxt = taddr_r + AW'(1);
        if (dim_last) begin
          dim_nxt = '0;
          ent_nxt = ent_r + EW'(1);
        end else begin
          dim_nxt = dim_r + DW'(1);
        end
        if (strong_hit || (dim_last && ent_last)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ent_r      <= '0;
      dim_r      <= '0;
      taddr_r    <= '0;
      last_ent_r <= '0;
      c1_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      ent_r      <= ent_nxt;
      dim_r      <= dim_nxt;
      taddr_r    <= taddr_nxt;
      last_ent_r <= last_ent_nxt;
      c1_r       <= issue_ctl;
    end
  end

  // align label with the distance pipeline
  always_ff @(posedge clk) begin
    lbla_r <= lbl_q;
    lblb_r <= lbla_r;
  end

  tnnm_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (c1_r),
    .tbl_i      (tbl_q),
    .qry_i      (qry_q),
    .pend_o     (pend),
    .dist_vld_o (dist_vld),
    .dist_o     (dist_sq)
  );

  // best-match tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      strong_r <= 1'b0;
    end else if (go) begin
      found_r  <= 1'b0;
      strong_r <= 1'b0;
    end else if (strong_hit) begin
      found_r  <= 1'b1;
      strong_r <= 1'b1;
    end else if (dist_vld && !strong_r && (dist_sq < best_r)) begin
      found_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      best_r <= accept_thr_r;
    end else if (strong_hit || (dist_vld && !strong_r && (dist_sq < best_r))) begin
      best_r     <= dist_sq;
      best_lbl_r <= lblb_r;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_found_r  <= found_r;
      out_label_r  <= found_r ? best_lbl_r : '0;
      out_strong_r <= strong_r;
      out_dist_r   <= found_r ? best_r : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_match_label      = out_label_r;
  assign out_strong_match     = out_strong_r;
  assign out_best_distance_sq = out_dist_r;

`ifndef NO_ASSERTIONS
  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DRAIN))
    else $error("result word without a finished walk");

  a_strong_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    strong_r |-> found_r)
    else $error("strong match flagged without a chosen entry");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_query_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy)
    else $error("last query word did not start a walk");

  a_idle_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !c1_r.vld)
    else $error("table read in flight while idle");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thresholded nearest-neighbour matcher.
// ----------------------------------------------------------------------------
// Loads labelled descriptors and streams query words with random gaps. A
// behavioral copy of the table, the query buffer and the search runs beside
// the block, and each match word is compared field by field with it. Tests
// begin with hand-built entries that sit between, on and under the
// thresholds. Random phases follow, each with its own register settings.
// The run ends with an exact copy of the query planted after the stored
// entries.
// ----------------------------------------------------------------------------
module tb_top;
  import tnnm_pkg::*;

  localparam int TBL_DEPTH      = MAX_ENTRIES_DEF * DIMS_DEF;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int PHASE_WORDS    = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [DIST_W-1:0]    THR_TOP   = 39'd549739036800;

  typedef struct packed {
    logic                     req;
    logic [ENTRY_W-1:0]       entry;
    logic [DIM_W-1:0]         dim;
    logic signed [COMP_W-1:0] comp;
    logic [LABEL_W-1:0]       label;
    logic                     last;
  } word_t;

  typedef struct packed {
    logic               found;
    logic [LABEL_W-1:0] label;
    logic               strong_flag;
    logic [DIST_W-1:0]  dist_sq;
  } match_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_req_type = 1'b0;
  logic [ENTRY_W-1:0]       in_entry_index = '0;
  logic [DIM_W-1:0]         in_dim_index = '0;
  logic signed [COMP_W-1:0] in_component = '0;
  logic [LABEL_W-1:0]       in_label_id = '0;
  logic                     in_last_element = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  logic                     out_valid;
  logic                     out_found;
  logic [LABEL_W-1:0]       out_match_label;
  logic                     out_strong_match;
  logic [DIST_W-1:0]        out_best_distance_sq;

  // behavioral copy of the block
  logic signed [COMP_W-1:0] tbl_comp [TBL_DEPTH];
  logic [LABEL_W-1:0]       tbl_label [MAX_ENTRIES_DEF];
  logic signed [COMP_W-1:0] qry_comp [DIMS_DEF];
  logic [COUNT_W-1:0]       reg_count;
  logic [DIST_W-1:0]        reg_strong;
  logic [DIST_W-1:0]        reg_accept;

  // stimulus side view of what has been written
  int                  gen_base [DIMS_DEF];
  int                  gen_query [DIMS_DEF];
  bit [DIMS_DEF-1:0]   gen_dims [MAX_ENTRIES_DEF];
  int                  gen_prefix = 0;

  word_t  word_queue [$];
  match_t match_queue [$];
  word_t  drv_word;
  match_t want;
  logic   took_word = 1'b0;
  int     idle_pct = 0;
  int     sent_words = 0;
  int     taken_words = 0;
  int     fail_count = 0;
  int     quiet_cycles = 0;

  thresholded_nearest_neighbour_match DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_entry_index       (in_entry_index),
    .in_dim_index         (in_dim_index),
    .in_component         (in_component),
    .in_label_id          (in_label_id),
    .in_last_element      (in_last_element),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_found            (out_found),
    .out_match_label      (out_match_label),
    .out_strong_match     (out_strong_match),
    .out_best_distance_sq (out_best_distance_sq)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic match_t search_table();
    match_t            res;
    logic [DIST_W-1:0] best;
    longint unsigned   sum;
    longint            diff;
    int                limit;
    res   = '0;
    best  = reg_accept;
    limit = (reg_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(reg_count);
    for (int e = 0; e < limit; e++) begin
      sum = 0;
      for (int d = 0; d < DIMS_DEF; d++) begin
        diff = longint'(tbl_comp[e * DIMS_DEF + d]) - longint'(qry_comp[d]);
        sum += diff * diff;
      end
      if (sum > DIST_MAX) sum = DIST_MAX;
      if (sum < reg_strong) begin
        res.found       = 1'b1;
        res.strong_flag = 1'b1;
        res.label       = tbl_label[e];
        res.dist_sq     = sum[DIST_W-1:0];
        return res;
      end
      if (sum < best) begin
        best        = sum[DIST_W-1:0];
        res.found   = 1'b1;
        res.label   = tbl_label[e];
        res.dist_sq = best;
      end
    end
    return res;
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int near(int dim, int amp);
    return clip16(gen_base[dim] + int'($urandom_range(2 * amp)) - amp);
  endfunction

  function automatic int pick_amp();
    case ($urandom_range(5))
      0: return 0;
      1: return 64;
      2: return 512;
      3: return 2048;
      4: return 8192;
      default: return 32768;
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] pick_thr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(6))
      0: return '0;
      1: return THR_TOP;
      2: return DIST_MAX;
      3: return $urandom_range(1) ? STRONG_THR_RESET : ACCEPT_THR_RESET;
      4: return DIST_W'($urandom_range(200000000));
      5: return DIST_W'($urandom_range(2000000000));
      default: return r[DIST_W-1:0];
    endcase
  endfunction

  task automatic push_word(logic req, int entry, int dim, int comp, int label, logic last);
    word_t w;
    w.req   = req;
    w.entry = ENTRY_W'(entry);
    w.dim   = DIM_W'(dim);
    w.comp  = COMP_W'(comp);
    w.label = LABEL_W'(label);
    w.last  = last;
    word_queue = {word_queue, w};
    sent_words++;
    if (req == REQ_LOAD) gen_dims[entry][dim] = 1'b1;
    else gen_query[dim] = comp;
    while (gen_prefix < MAX_ENTRIES_DEF && &gen_dims[gen_prefix]) gen_prefix++;
  endtask

  // re-send one stored query component and start the search
  task automatic ask();
    int d;
    d = $urandom_range(DIMS_DEF - 1);
    push_word(REQ_QUERY, $urandom_range(1023), d, gen_query[d], $urandom_range(255), 1'b1);
  endtask

  task automatic load_entry(int e, int amp, int label);
    for (int d = 0; d < DIMS_DEF; d++)
      push_word(REQ_LOAD, e, d, near(d, amp), label, 1'($urandom_range(1)));
  endtask

  task automatic wait_quiet();
    while (taken_words != sent_words || match_queue.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_regs(int count, logic [DIST_W-1:0] strong_thr,
                          logic [DIST_W-1:0] accept);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    wait_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_wdata <= {junk[CFG_W-1:COUNT_W], count[COUNT_W-1:0]};
    @(negedge clk);
    cfg_index <= CFG_STRONG_THR;
    cfg_wdata <= strong_thr;
    @(negedge clk);
    cfg_index <= CFG_ACCEPT_THR;
    cfg_wdata <= accept;
    if ($urandom_range(3) == 0) begin
      @(negedge clk);
      cfg_index <= CFG_SPARE;
      cfg_wdata <= junk[CFG_W-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_word) begin
      if (word_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drv_word = word_queue.pop_front();
        start           <= 1'b1;
        in_req_type     <= drv_word.req;
        in_entry_index  <= drv_word.entry;
        in_dim_index    <= drv_word.dim;
        in_component    <= drv_word.comp;
        in_label_id     <= drv_word.label;
        in_last_element <= drv_word.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      took_word    <= 1'b0;
      quiet_cycles <= 0;
      reg_count    = '0;
      reg_strong   = STRONG_THR_RESET;
      reg_accept   = ACCEPT_THR_RESET;
    end else begin
      took_word <= start && !busy;
      if (out_valid) begin
        if (match_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("match word with nothing pending: found=%0b label=%0d strong=%0b dist=%0d",
                     out_found, out_match_label, out_strong_match, out_best_distance_sq);
        end else begin
          want = match_queue.pop_front();
          if (out_found !== want.found || out_match_label !== want.label ||
              out_strong_match !== want.strong_flag ||
              out_best_distance_sq !== want.dist_sq) begin
            fail_count++;
            if (fail_count <= 10)
              $display("match mismatch: expected found=%0b label=%0d strong=%0b dist=%0d, %s",
                       want.found, want.label, want.strong_flag, want.dist_sq,
                       $sformatf("got found=%0b label=%0d strong=%0b dist=%0d", out_found,
                                 out_match_label, out_strong_match, out_best_distance_sq));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTRY_COUNT: reg_count  = cfg_wdata[COUNT_W-1:0];
          CFG_STRONG_THR:  reg_strong = cfg_wdata[DIST_W-1:0];
          CFG_ACCEPT_THR:  reg_accept = cfg_wdata[DIST_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        taken_words++;
        if (in_req_type == REQ_LOAD) begin
          tbl_comp[int'(in_entry_index) * DIMS_DEF + int'(in_dim_index)] = in_component;
          tbl_label[in_entry_index] = in_label_id;
        end else begin
          qry_comp[in_dim_index] = in_component;
          if (in_last_element) match_queue = {match_queue, search_table()};
        end
      end
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int d, e, k, n, ph, pick, amp, lbl, phase_end, count, comp;
    for (d = 0; d < DIMS_DEF; d++) gen_base[d] = int'($urandom_range(32767)) - 16384;
    gen_base[0]          = -32768;
    gen_base[DIMS_DEF-1] = 32767;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // entry count 0 after reset: nothing is searched
    push_word(REQ_QUERY, 1023, 0, -32768, 255, 1'b1);
    for (d = 0; d < DIMS_DEF; d++)
      push_word(REQ_QUERY, $urandom_range(1023), d, gen_base[d], $urandom_range(255),
                d == DIMS_DEF - 1);

    // between thresholds, under strong, far extremes, exact copy
    for (e = 0; e < 4; e++) begin
      lbl = (e == 0) ? 0 : (e == 1) ? 255 : $urandom_range(255);
      for (d = 0; d < DIMS_DEF; d++) begin
        comp = gen_base[d];
        if (e == 0 && d == 5) comp += 8000;
        if (e == 1 && d == 9) comp += 7000;
        if (e == 2) comp = (gen_base[d] >= 0) ? -32768 : 32767;
        push_word(REQ_LOAD, e, d, comp, lbl, 1'($urandom_range(1)));
      end
    end
    set_regs(1, STRONG_THR_RESET, ACCEPT_THR_RESET);
    ask();
    set_regs(2, STRONG_THR_RESET, ACCEPT_THR_RESET);
    ask();
    set_regs(4, '0, THR_TOP);
    ask();
    set_regs(1, '0, 39'd64000000);
    ask();
    set_regs(2, 39'd49000000, DIST_MAX);
    ask();
    set_regs(4, DIST_MAX, '0);
    ask();

    for (ph = 0; ph < 8; ph++) begin
      case ($urandom_range(3))
        0: count = 0;
        1: count = gen_prefix;
        default: count = $urandom_range(gen_prefix, 1);
      endcase
      set_regs(count, pick_thr(), pick_thr());
      idle_pct  = (ph % 3 == 1) ? 48 : (ph % 3 == 2) ? 19 : 0;
      if (ph % 4 == 1) load_entry(gen_prefix, pick_amp(), $urandom_range(255));
      phase_end = sent_words + PHASE_WORDS;
      while (sent_words < phase_end) begin
        pick = $urandom_range(99);
        amp  = pick_amp();
        if (pick < 40) begin
          n = $urandom_range(4, 1);
          for (k = 0; k < n; k++) begin
            d = $urandom_range(DIMS_DEF - 1);
            push_word(REQ_QUERY, $urandom_range(1023), d, near(d, amp), $urandom_range(255),
                      k == n - 1);
          end
        end else if (pick < 70) begin
          e = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(gen_prefix - 1);
          d = $urandom_range(DIMS_DEF - 1);
          push_word(REQ_LOAD, e, d, near(d, amp), $urandom_range(255),
                    1'($urandom_range(1)));
        end else if (pick < 82) begin
          d = $urandom_range(DIMS_DEF - 1);
          push_word(REQ_QUERY, $urandom_range(1023), d, near(d, amp), $urandom_range(255), 1'b0);
        end else begin
          // pull part of a stored entry toward the current query
          e   = $urandom_range(gen_prefix - 1);
          n   = $urandom_range(8, 1);
          amp = ($urandom_range(1) == 0) ? 0 : 512;
          for (k = 0; k < n; k++) begin
            d = $urandom_range(DIMS_DEF - 1);
            push_word(REQ_LOAD, e, d,
                      clip16(gen_query[d] + int'($urandom_range(2 * amp)) - amp),
                      $urandom_range(255), 1'b0);
          end
        end
      end
    end

    // plant an exact copy of the query right after the stored entries
    wait_quiet();
    idle_pct = 0;
    e   = gen_prefix;
    lbl = $urandom_range(255);
    for (d = 0; d < DIMS_DEF; d++)
      push_word(REQ_LOAD, e, d, gen_query[d], lbl, 1'b0);
    set_regs(gen_prefix, '0, THR_TOP);
    ask();
    set_regs(gen_prefix, 39'd1, '0);
    ask();

    wait_quiet();
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
